// ----- rtl/akesc_pkg.sv -----
// ----------------------------------------------------------------------------
// akesc_pkg
// Shared constants and the CSI number decode for the ANSI key escape parser.
// ----------------------------------------------------------------------------
package akesc_pkg;

  // Characters that steer the parser
  localparam logic [6:0] CHAR_ESC      = 7'h1B;
  localparam logic [6:0] CHAR_LBRACKET = 7'h5B;  // '['
  localparam logic [6:0] CHAR_UPPER_O  = 7'h4F;  // 'O'
  localparam logic [6:0] CHAR_TILDE    = 7'h7E;  // '~'
  localparam logic [6:0] CHAR_TWO      = 7'h32;  // '2'
  localparam logic [6:0] CHAR_ZERO     = 7'h30;
  localparam logic [6:0] CHAR_NINE     = 7'h39;
  localparam logic [6:0] CHAR_LOWER_A  = 7'h61;
  localparam logic [6:0] CHAR_LOWER_Z  = 7'h7A;
  localparam logic [6:0] CHAR_UPPER_P  = 7'h50;
  localparam logic [6:0] CHAR_UPPER_S  = 7'h53;
  localparam logic [6:0] CHAR_UPPER_A  = 7'h41;
  localparam logic [6:0] CHAR_UPPER_B  = 7'h42;
  localparam logic [6:0] CHAR_UPPER_C  = 7'h43;
  localparam logic [6:0] CHAR_UPPER_D  = 7'h44;
  localparam logic [6:0] CHAR_UPPER_F  = 7'h46;
  localparam logic [6:0] CHAR_UPPER_H  = 7'h48;

  // Key codes: scan code high byte, ascii low byte
  localparam logic [15:0] CODE_UP        = 16'h4800;
  localparam logic [15:0] CODE_DOWN      = 16'h5000;
  localparam logic [15:0] CODE_RIGHT     = 16'h4D00;
  localparam logic [15:0] CODE_LEFT      = 16'h4B00;
  localparam logic [15:0] CODE_END       = 16'h4F00;
  localparam logic [15:0] CODE_HOME      = 16'h4700;
  localparam logic [15:0] CODE_F1        = 16'h3B00;
  localparam logic [15:0] CODE_SHIFT_F1  = 16'h5400;
  localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;

  localparam logic [15:0] ESCAPE_CODE_RESET = 16'h011B;
  localparam logic [7:0]  NUMBER_MAX        = 8'hFF;

  // Decode of the number in ESC [ number ~
  function automatic logic [15:0] csi_number_code(input logic [7:0] n);
    logic [15:0] code;
    unique case (n)
      8'd1:    code = 16'h4700;
      8'd3:    code = 16'h5300;
      8'd4:    code = 16'h4F00;
      8'd5:    code = 16'h4900;
      8'd6:    code = 16'h5100;
      8'd11:   code = 16'h3B00;
      8'd12:   code = 16'h3C00;
      8'd13:   code = 16'h3D00;
      8'd14:   code = 16'h3E00;
      8'd15:   code = 16'h3F00;
      8'd17:   code = 16'h4000;
      8'd18:   code = 16'h4100;
      8'd19:   code = 16'h4200;
      8'd20:   code = 16'h4300;
      8'd21:   code = 16'h4400;
      default: code = 16'h0000;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/ansi_key_escape_to_scancode_top.sv -----
// Takes one 7-bit character per transaction (or an end-of-buffer mark) and
// turns ANSI terminal key sequences into 16-bit PC keyboard codes. A character
// is accepted every clock cycle unless stalled, and its key code, if any, is
// registered for output. The parse state and digit accumulator are
// updated in a single registered pass, and results go through a two-entry
// output buffer (output register plus skid register), so input keeps flowing
// while a result waits; the input stalls only when both entries are full.
// Characters that produce a zero code give no output transaction. The escape
// code register may be written through the configuration channel while idle.
// ----------------------------------------------------------------------------
// ansi_key_escape_to_scancode_top
// ANSI key escape sequence parser producing PC keyboard codes.
// ----------------------------------------------------------------------------
module ansi_key_escape_to_scancode_top
  import akesc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [6:0]  char_value,
  input  logic        end_of_buffer,
  input  logic [15:0] lookup_code,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] key_code,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] escape_key_code
);

  typedef enum logic [2:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_CSI,
    MODE_SS3,
    MODE_SS3_SHIFT,
    MODE_ERROR
  } mode_t;

  mode_t       mode, mode_next;
  logic [7:0]  number, number_next;
  logic [15:0] esc_code;
  logic [15:0] code_next;
  logic [11:0] acc;
  logic        in_fire, out_fire, res_valid;
  logic        skid_valid;
  logic [15:0] skid_code;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign res_valid = in_fire && (code_next != 16'h0000);

  // digit accumulate, saturated below
  assign acc = 12'(number) * 12'd10 + 12'(char_value[3:0]);

  // parse step
  always_comb begin
    mode_next   = mode;
    number_next = number;
    code_next   = 16'h0000;
    unique case (mode)
      MODE_ESC: begin
        if (end_of_buffer) begin
          mode_next = MODE_PLAIN;
          code_next = esc_code;
        end else if (char_value == CHAR_LBRACKET) begin
          mode_next   = MODE_CSI;
          number_next = 8'd0;
        end else if (char_value == CHAR_UPPER_O) begin
          mode_next = MODE_SS3;
        end else if (char_value >= CHAR_LOWER_A && char_value <= CHAR_LOWER_Z) begin
          mode_next = MODE_PLAIN;
          code_next = lookup_code & HIGH_BYTE_MASK;
        end else begin
          mode_next = MODE_ERROR;
        end
      end
      MODE_CSI: begin
        mode_next = MODE_PLAIN;
        if (end_of_buffer) begin
          code_next = 16'h0000;
        end else if (char_value == CHAR_UPPER_A) begin
          code_next = CODE_UP;
        end else if (char_value == CHAR_UPPER_B) begin
          code_next = CODE_DOWN;
        end else if (char_value == CHAR_UPPER_C) begin
          code_next = CODE_RIGHT;
        end else if (char_value == CHAR_UPPER_D) begin
          code_next = CODE_LEFT;
        end else if (char_value == CHAR_UPPER_F) begin
          code_next = CODE_END;
        end else if (char_value == CHAR_UPPER_H) begin
          code_next = CODE_HOME;
        end else if (char_value == CHAR_TILDE) begin
          code_next = csi_number_code(number);
        end else if (char_value >= CHAR_ZERO && char_value <= CHAR_NINE) begin
          mode_next   = MODE_CSI;
          number_next = (acc > 12'(NUMBER_MAX)) ? NUMBER_MAX : acc[7:0];
        end else begin
          mode_next = MODE_ERROR;
        end
      end
      MODE_SS3: begin
        if (end_of_buffer) begin
          mode_next = MODE_PLAIN;
        end else if (char_value >= CHAR_UPPER_P && char_value <= CHAR_UPPER_S) begin
          mode_next = MODE_PLAIN;
          code_next = CODE_F1 + {6'd0, char_value[1:0], 8'd0};
        end else if (char_value == CHAR_TWO) begin
          mode_next = MODE_SS3_SHIFT;
        end else begin
          mode_next = MODE_ERROR;
        end
      end
      MODE_SS3_SHIFT: begin
        if (end_of_buffer) begin
          mode_next = MODE_PLAIN;
        end else if (char_value >= CHAR_UPPER_P && char_value <= CHAR_UPPER_S) begin
          mode_next = MODE_PLAIN;
          code_next = CODE_SHIFT_F1 + {6'd0, char_value[1:0], 8'd0};
        end else begin
          mode_next = MODE_ERROR;
        end
      end
      MODE_ERROR: begin
        if (end_of_buffer) begin
          mode_next = MODE_PLAIN;
        end
      end
      default: begin
        // plain mode, and the unused codes
        mode_next = (!end_of_buffer && char_value == CHAR_ESC) ? MODE_ESC : MODE_PLAIN;
        if (!end_of_buffer && char_value != CHAR_ESC) begin
          code_next = lookup_code;
        end
      end
    endcase
  end

  // parse state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_PLAIN;
      number   <= 8'd0;
      esc_code <= ESCAPE_CODE_RESET;
    end else begin
      if (in_fire) begin
        mode   <= mode_next;
        number <= number_next;
      end
      if (cfg_valid && cfg_ready) begin
        esc_code <= escape_key_code;
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        key_code   <= skid_code;
        skid_valid <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
        key_code  <= code_next;
      end else begin
        skid_valid <= 1'b1;
        skid_code  <= code_next;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_code_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_code != 16'h0000)
    else $error("zero key code presented");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_fire |=> skid_valid && $stable(skid_code))
    else $error("skid entry lost or changed while output stalled");

  a_reset_state: assert property (@(posedge clk)
    rst |=> mode == MODE_PLAIN && number == 8'd0 && !out_valid && !skid_valid)
    else $error("reset did not clear parser state");

  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    in_fire && mode == MODE_ERROR |-> !res_valid)
    else $error("result produced while discarding a bad sequence");

endmodule
